// File: rtl/sust_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sust_pkg: shared types for the sorted unique set table
// Item layouts, status and operation codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sust_pkg;

    // Operation codes carried in the op field of an input item
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_OK        = 3'd3,
        ST_INVALID   = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // Input item
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_in;

    // Result item
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] entry_value;
        logic [4:0]         entry_count;
    } t_out;

    // Read address source relative to the pointer
    typedef enum logic [1:0] {
        RS_PTR = 2'd0,
        RS_DEC = 2'd1,
        RS_INC = 2'd2
    } t_rsel;

    // Commands from the controller
    typedef struct packed {
        logic    load;       // capture the accepted item
        logic    ptr_zero;
        logic    ptr_pos;    // pointer to position minus one
        logic    ptr_cnt;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    slot_ptr;   // remember the insert slot
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        logic    wr_val;     // write the item value, else the read data
        logic    cnt_inc;
        logic    cnt_dec;
        logic    got_load;
        logic    set_st;
        t_status st;
        logic    out_load;
    } t_cmd;

    // Status flags back to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       cnt_zero;
        logic       cnt_full;
        logic       pos_bad;
        logic       ptr_at_cnt;
        logic       ptr_at_slot;
        logic       ptr_next_cnt;
        logic       rd_less;
        logic       rd_equal;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/sorted_unique_set_table_core.sv
`default_nettype none
// One item at a time: a new item is taken only in the idle state, after the result of
// the last item has been loaded into the output register. Entries are read and moved
// one by one through the single registered read port of the entry RAM, and a stalled
// result holds the sequencer until the output register is free.
// Reset empties the table at once (count cleared); entry contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_unique_set_table_core: sorted table of unique signed values
// Insert at the sorted place, delete or read at a 1-based position; every
// item gives one result with status, value and entry count.
// ----------------------------------------------------------------------------
module sorted_unique_set_table_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire sust_pkg::t_in i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sust_pkg::t_out     o_out_item
);
    import sust_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    sust_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage and result register
    sust_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// File: rtl/sust_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sust_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: rtl/sust_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sust_datapath: storage, pointers and result register
// Holds the entry RAM, the entry count, the walking pointer, the captured
// item and the output register, and acts on controller commands.
// ----------------------------------------------------------------------------
module sust_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sust_pkg::t_in  i_in_item,
    input  wire sust_pkg::t_cmd i_cmd,
    output sust_pkg::t_stat     o_stat,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    output sust_pkg::t_out      o_out_item
);
    import sust_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);

    logic [1:0]         r_op;
    logic signed [31:0] r_val;
    logic [4:0]         r_pos;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_slot;
    logic [31:0]        r_got;
    t_status            r_st;
    t_out               r_out;
    logic               r_out_vld;

    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      pos_m1;
    logic [CW:0]        ptr_p1;
    logic [CW-1:0]      rd_ptr;
    logic [31:0]        rd_data;
    logic [31:0]        wr_data;
    logic               out_free;

    assign pos_x  = XW'(r_pos);
    assign cnt_x  = XW'(r_cnt);
    assign pos_m1 = pos_x - XW'(1);
    assign ptr_p1 = {1'b0, r_ptr} + (CW+1)'(1);

    // Select the read address around the pointer
    always_comb begin
        case (i_cmd.rd_sel)
            RS_PTR:  rd_ptr = r_ptr;
            RS_DEC:  rd_ptr = r_ptr - CW'(1);
            RS_INC:  rd_ptr = ptr_p1[CW-1:0];
            default: rd_ptr = r_ptr;
        endcase
    end

    assign wr_data = i_cmd.wr_val ? r_val : rd_data;

    sust_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_ptr[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_ptr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_item.op;
            r_val <= i_in_item.value;
            r_pos <= i_in_item.position;
        end
    end

    // Advance the pointer and remember the insert slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.ptr_zero) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_pos) begin
            r_ptr <= pos_m1[CW-1:0];
        end else if (i_cmd.ptr_cnt) begin
            r_ptr <= r_cnt;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= ptr_p1[CW-1:0];
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - CW'(1);
        end
        if (i_cmd.slot_ptr) begin
            r_slot <= r_ptr;
        end
        if (i_cmd.got_load) begin
            r_got <= rd_data;
        end
        if (i_cmd.set_st) begin
            r_st <= i_cmd.st;
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // Output register: load a result, drop it once taken
    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status      <= r_st;
            r_out.entry_value <= (r_st == ST_OK) ? r_got : 32'sd0;
            r_out.entry_count <= cnt_x[4:0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Flags for the controller
    assign o_stat.op           = r_op;
    assign o_stat.cnt_zero     = (r_cnt == '0);
    assign o_stat.cnt_full     = (r_cnt == CNT_MAX);
    assign o_stat.pos_bad      = (r_pos == 5'd0) || (pos_x > cnt_x);
    assign o_stat.ptr_at_cnt   = (r_ptr == r_cnt);
    assign o_stat.ptr_at_slot  = (r_ptr == r_slot);
    assign o_stat.ptr_next_cnt = (ptr_p1 == {1'b0, r_cnt});
    assign o_stat.rd_less      = ($signed(rd_data) < r_val);
    assign o_stat.rd_equal     = ($signed(rd_data) == r_val);
    assign o_stat.out_free     = out_free;

endmodule
`default_nettype wire

// File: rtl/sust_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sust_ctrl: sequencer for the sorted unique set table
// Walks the table one entry at a time, a read state then an act state, for search,
// shift-up on insert and shift-down on delete, then posts the result.
// ----------------------------------------------------------------------------
module sust_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire sust_pkg::t_stat i_stat,
    output sust_pkg::t_cmd       o_cmd
);
    import sust_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_SCAN_RD  = 11'b000_0000_0100,
        S_SCAN_EV  = 11'b000_0000_1000,
        S_SHF_RD   = 11'b000_0001_0000,
        S_SHF_WR   = 11'b000_0010_0000,
        S_RD_ISSUE = 11'b000_0100_0000,
        S_RD_EV    = 11'b000_1000_0000,
        S_DEL_RD   = 11'b001_0000_0000,
        S_DEL_WR   = 11'b010_0000_0000,
        S_POST     = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        cmd     = '0;
        cmd.st  = ST_INVALID;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        cmd.ptr_zero = 1'b1;
                        n_state      = S_SCAN_RD;
                    end
                    OP_DELETE, OP_READ: begin
                        if (i_stat.cnt_zero) begin
                            cmd.set_st = 1'b1;
                            cmd.st     = ST_EMPTY;
                            n_state    = S_POST;
                        end else if (i_stat.pos_bad) begin
                            cmd.set_st = 1'b1;
                            cmd.st     = ST_INVALID;
                            n_state    = S_POST;
                        end else begin
                            cmd.ptr_pos = 1'b1;
                            n_state     = S_RD_ISSUE;
                        end
                    end
                    default: begin
                        // unused op code: report invalid, table untouched
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_INVALID;
                        n_state    = S_POST;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (i_stat.ptr_at_cnt) begin
                    // value goes past the last entry
                    if (i_stat.cnt_full) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_FULL;
                        n_state    = S_POST;
                    end else begin
                        cmd.slot_ptr = 1'b1;
                        n_state      = S_SHF_RD;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_PTR;
                    n_state    = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (i_stat.rd_less) begin
                    cmd.ptr_inc = 1'b1;
                    n_state     = S_SCAN_RD;
                end else if (i_stat.rd_equal) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_DUPLICATE;
                    n_state    = S_POST;
                end else if (i_stat.cnt_full) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_FULL;
                    n_state    = S_POST;
                end else begin
                    cmd.slot_ptr = 1'b1;
                    cmd.ptr_cnt  = 1'b1;
                    n_state      = S_SHF_RD;
                end
            end
            S_SHF_RD: begin
                if (i_stat.ptr_at_slot) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_val  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.set_st  = 1'b1;
                    cmd.st      = ST_INSERTED;
                    n_state     = S_POST;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_DEC;
                    n_state    = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                // move the entry below up one place
                cmd.wr_en   = 1'b1;
                cmd.ptr_dec = 1'b1;
                n_state     = S_SHF_RD;
            end
            S_RD_ISSUE: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RS_PTR;
                n_state    = S_RD_EV;
            end
            S_RD_EV: begin
                cmd.got_load = 1'b1;
                if (i_stat.op == OP_READ) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_OK;
                    n_state    = S_POST;
                end else begin
                    n_state = S_DEL_RD;
                end
            end
            S_DEL_RD: begin
                if (i_stat.ptr_next_cnt) begin
                    cmd.cnt_dec = 1'b1;
                    cmd.set_st  = 1'b1;
                    cmd.st      = ST_OK;
                    n_state     = S_POST;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_INC;
                    n_state    = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                // move the entry above down one place
                cmd.wr_en   = 1'b1;
                cmd.ptr_inc = 1'b1;
                n_state     = S_DEL_RD;
            end
            S_POST: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire
